// File: rtl/tpf_pkg.sv
// Shared types, constants and byte selection for the telemetry packet framer.
`default_nettype none
package tpf_pkg;

  localparam int unsigned FrameLen = 19;
  localparam int unsigned PosW     = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  localparam logic [7:0]      HdrA    = 8'hAA;
  localparam logic [7:0]      HdrB    = 8'h56;
  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  typedef struct packed {
    logic signed [15:0] accel_y;
    logic signed [15:0] pitch;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] target_speed;
    logic signed [31:0] distance;
    logic        [7:0]  phase_code;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_t;

  // One queued record together with the sequence number it was given.
  typedef struct packed {
    in_t        rec;
    logic [7:0] seq;
  } job_t;

  // Byte of the frame body at a given position; the check byte is not covered here.
  function automatic logic [7:0] body_byte(job_t job, logic [PosW-1:0] pos);
    logic [7:0] b;
    unique case (pos)
      5'd0:    b = HdrA;
      5'd1:    b = HdrB;
      5'd2:    b = job.seq;
      5'd3:    b = job.rec.accel_y[7:0];
      5'd4:    b = job.rec.accel_y[15:8];
      5'd5:    b = job.rec.pitch[7:0];
      5'd6:    b = job.rec.pitch[15:8];
      5'd7:    b = job.rec.left_speed[7:0];
      5'd8:    b = job.rec.left_speed[15:8];
      5'd9:    b = job.rec.right_speed[7:0];
      5'd10:   b = job.rec.right_speed[15:8];
      5'd11:   b = job.rec.target_speed[7:0];
      5'd12:   b = job.rec.target_speed[15:8];
      5'd13:   b = job.rec.distance[7:0];
      5'd14:   b = job.rec.distance[15:8];
      5'd15:   b = job.rec.distance[23:16];
      5'd16:   b = job.rec.distance[31:24];
      5'd17:   b = job.rec.phase_code;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/tpf_front.sv
// Front end: accepts records and tags each with its frame sequence number.
`default_nettype none
module tpf_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire tpf_pkg::in_t in_data_i,
  output logic              push_o,
  output tpf_pkg::job_t     push_job_o,
  input  wire logic         full_i
);

  logic [7:0] seq_q, seq_d;

  assign in_ready_o      = !full_i;
  assign push_o          = in_valid_i && !full_i;
  assign push_job_o.rec  = in_data_i;
  assign push_job_o.seq  = seq_q;

  always_comb begin
    seq_d = seq_q;
    if (push_o) begin
      seq_d = seq_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= 8'd0;
    end else begin
      seq_q <= seq_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tpf_fifo.sv
// Short record queue between the front end and the byte serializer.
`default_nettype none
module tpf_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tpf_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output tpf_pkg::job_t      head_o
);

  tpf_pkg::job_t entries_q [tpf_pkg::QueueDepth];
  logic [tpf_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [tpf_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == tpf_pkg::QCntW'(tpf_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entries_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + tpf_pkg::QPtrW'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + tpf_pkg::QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + tpf_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - tpf_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tpf_pkg::QCntW'(tpf_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: rtl/tpf_back.sv
// Back end: serializes the head record into frame beats and builds the check byte.
`default_nettype none
module tpf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire tpf_pkg::job_t job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tpf_pkg::out_t      out_data_o
);

  logic [tpf_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]               xor_q, xor_d;
  logic                     out_valid_q, out_valid_d;
  tpf_pkg::out_t            out_q, out_d;
  logic                     advance;
  logic                     at_last;
  logic [7:0]               body;

  assign advance = job_valid_i && (!out_valid_q || out_ready_i);
  assign at_last = (pos_q == tpf_pkg::LastPos);
  assign body    = tpf_pkg::body_byte(job_i, pos_q);
  assign pop_o   = advance && at_last;

  always_comb begin
    pos_d       = pos_q;
    xor_d       = xor_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      if (at_last) begin
        out_d.frame_byte = xor_q;
        out_d.frame_last = 1'b1;
        pos_d            = '0;
        xor_d            = 8'h00;
      end else begin
        out_d.frame_byte = body;
        out_d.frame_last = 1'b0;
        pos_d            = pos_q + tpf_pkg::PosW'(1);
        xor_d            = xor_q ^ body;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      xor_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= tpf_pkg::LastPos)
    else $error("byte position beyond frame");
  a_last_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && at_last |=> out_valid_q && out_q.frame_last && pos_q == '0)
    else $error("check byte not marked last");
  a_body_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !at_last |=> out_valid_q && !out_q.frame_last)
    else $error("body beat marked last");
  a_frame_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == '0 |-> xor_q == 8'h00)
    else $error("check accumulator not cleared at frame start");

endmodule
`default_nettype wire

// File: rtl/telemetry_packet_framer.sv
// Top level of the telemetry packet framer.
`default_nettype none
// Each accepted record becomes one 19-beat frame: header 0xAA 0x56, the sequence
// number, the five 16-bit values and the 32-bit distance little-endian, the phase
// byte, and an XOR check byte flagged as last. The serializer sends one beat per
// cycle while out_ready_i does not stall the output, and frames follow each other
// without gaps while the next record is already queued. A two-entry queue sits between the
// input and the serializer; the record being sent keeps its entry until its last
// beat, so one further record is taken ahead of the frame that is being sent. The
// sequence number starts at 0 after reset and wraps after 255.
module telemetry_packet_framer (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire tpf_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output tpf_pkg::out_t     out_data_o
);

  logic          push, full, pop, job_valid;
  tpf_pkg::job_t push_job, head_job;

  tpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  tpf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_o     (head_job)
  );

  tpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
